// ===== hdl/tte_pkg.sv =====
// Shared types and constants for the table-driven ANS encoder.
`default_nettype none

package tte_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_SYM_WRITE = 2'd0,
        OP_NS_WRITE  = 2'd1,
        OP_DATA      = 2'd2,
        OP_DRAIN     = 2'd3
    } t_opcode;

    // Result status carried on the output tuser
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_OVERFLOW = 2'd2
    } t_status;

    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned TLEN_W     = 14;
    localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

    // Input tdata, last field in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [7:0]  data_byte;
        logic [12:0] next_state_entry;
        logic [13:0] delta_find_state;
        logic [31:0] delta_nb_bits;
        logic [11:0] table_index;
    } t_in_data;

    // Output tdata, last field in the lowest bits
    typedef struct packed {
        logic [1:0]        pad;
        logic [TLEN_W-1:0] total_length;
        logic [7:0]        out_byte;
    } t_out_data;

    // Bit packer control from the sequencer
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_pack_ctrl;

    // Bit packer status back to the sequencer
    typedef struct packed {
        logic byte_ready;
        logic has_tail;
    } t_pack_stat;

endpackage

`default_nettype wire

// ===== hdl/tans_table_encoder.sv =====
// Top level of the table-driven ANS encoder: tables, buffers and the encode sequencer.
`default_nettype none

// Table-driven ANS encoder. Requests come in on the slave stream with the kind in
// tuser: symbol-table and next-state-table writes go straight to the memories, a
// data symbol is stored in the symbol buffer, and a drain request passes through a
// drain state and returns one byte (a 2-byte little-endian bit count first, then the
// payload). A data symbol flagged by tlast starts the encode, during which the input
// is held off: a symbol read, a table read, an nb step and a next-state read set up
// the initial state, then per symbol one symbol-buffer read, one table read, one
// next-state read and one packer step, plus an emit step for each byte popped from
// the packer into the output buffer, and a final flush. Tables and buffers power up
// undefined and have no clearing pass. Any request is taken only while the sequencer
// is idle and the output register is empty or being emptied in the same cycle.
module tans_table_encoder
    import tte_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS   = 4096,
    parameter int unsigned MAX_OUT_BYTES = 8192,
    parameter int unsigned TABLE_LOG     = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // table_index[11:0], delta_nb_bits[43:12], delta_find_state[57:44],
    // next_state_entry[70:58], data_byte[78:71], zero[79]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]            s_axis_tuser,
    // last_symbol
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_byte[7:0], total_length[21:8], zero[23:22]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // status[1:0]
    output logic [1:0]                 m_axis_tuser,
    // is_last
    output logic                       m_axis_tlast
);

    localparam int unsigned SB_AW = $clog2(MAX_SYMBOLS);
    localparam int unsigned SC_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int unsigned OB_AW = $clog2(MAX_OUT_BYTES);
    localparam int unsigned BC_W  = $clog2(MAX_OUT_BYTES + 1);
    localparam int unsigned DP_W  = $clog2(MAX_OUT_BYTES + 2);
    localparam int unsigned TS    = 1 << TABLE_LOG;
    localparam int unsigned NB_W  = $clog2(TABLE_LOG + 1);
    localparam int unsigned TLP1  = TABLE_LOG + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_ISYM, S_ITAB, S_INB, S_ISLOT, S_LOOP, S_SYM, S_TAB,
        S_CALC, S_FLUSH, S_EMIT, S_DRAIN
    } t_state;

    typedef enum logic {
        PH_LOADING,
        PH_DRAINING
    } t_phase;

    typedef enum logic [1:0] {
        DS_LO, DS_HI, DS_MEM, DS_ZERO
    } t_dsel;

    // Memories
    logic [7:0]  sym_mem [MAX_SYMBOLS];
    logic [7:0]  ob_mem  [MAX_OUT_BYTES];
    logic [31:0] nb_mem  [256];
    logic [13:0] fs_mem  [256];
    logic [12:0] ns_mem  [TS];

    logic [7:0]  r_sym_q;
    logic [31:0] r_dnb_q;
    logic [13:0] r_fs_q;
    logic [12:0] r_ns_q;
    logic [7:0]  r_ob_q;

    // Sequencer state
    t_state            r_state,  n_state;
    t_phase            r_phase,  n_phase;
    logic [SC_W-1:0]   r_scount, n_scount;
    logic [SB_AW-1:0]  r_idx,    n_idx;
    logic [BC_W-1:0]   r_bcount, n_bcount;
    logic [DP_W-1:0]   r_dptr,   n_dptr;
    logic [12:0]       r_cstate, n_cstate;
    logic [31:0]       r_t,      n_t;
    logic [4:0]        r_sh,     n_sh;
    logic              r_final,  n_final;
    t_dsel             r_dsel,   n_dsel;
    logic              r_dlast,  n_dlast;
    logic [TLEN_W-1:0] r_dtlen,  n_dtlen;
    logic              r_m_valid,  n_m_valid;
    logic [7:0]        r_m_byte,   n_m_byte;
    logic [TLEN_W-1:0] r_m_tlen,   n_m_tlen;
    t_status           r_m_status, n_m_status;
    logic              r_m_last,   n_m_last;

    t_in_data   w_in;
    t_opcode    w_op;
    t_out_data  w_out;
    logic       w_accept;
    logic       w_out_load;

    logic               w_sym_we;
    logic [SB_AW-1:0]   w_sym_waddr;
    logic               w_tab_we;
    logic               w_ns_we;
    logic [TABLE_LOG-1:0] w_ns_waddr;
    logic               w_ns_re;
    logic               w_ob_we;
    logic [OB_AW-1:0]   w_ob_raddr;

    logic [SC_W-1:0]    w_base_cnt;
    logic               w_ovf;
    logic [31:0]        w_total;

    // Encode datapath
    logic [31:0]          w_sum;
    logic [15:0]          w_nb_raw;
    logic [NB_W-1:0]      w_nb;
    logic [15:0]          w_nb0;
    logic [31:0]          w_t;
    logic [15:0]          w_base;
    logic [15:0]          w_slot16;
    logic [TABLE_LOG-1:0] w_slot;
    logic [NB_W-1:0]      w_pk_nb;
    logic [TABLE_LOG:0]   w_mask;
    logic [15:0]          w_cs_ext;
    logic [TABLE_LOG-1:0] w_pk_bits;

    t_pack_ctrl  w_pk_ctrl;
    t_pack_stat  w_pk_stat;
    logic [7:0]  w_pk_byte;
    logic [15:0] w_payload;

    assign w_in     = t_in_data'(s_axis_tdata);
    assign w_op     = t_opcode'(s_axis_tuser);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || m_axis_tready);

    assign w_out.pad          = '0;
    assign w_out.total_length = r_m_tlen;
    assign w_out.out_byte     = r_m_byte;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = w_out;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tlast  = r_m_last;

    // nb for one encode step, saturated to the table log
    assign w_sum    = 32'(r_cstate) + r_dnb_q;
    assign w_nb_raw = w_sum[31:16];
    assign w_nb     = (w_nb_raw > 16'(TABLE_LOG)) ? NB_W'(TABLE_LOG) : w_nb_raw[NB_W-1:0];

    // Initial state: rounded nb and the shifted start offset
    assign w_nb0 = 16'((r_dnb_q + ROUND_HALF) >> 16);
    assign w_t   = {w_nb0, 16'h0000} - r_dnb_q;

    // Shared slot adder for init and encode steps
    assign w_base   = (r_state == S_ISLOT) ? 16'(r_t >> r_sh) : 16'(r_cstate >> w_nb);
    assign w_slot16 = w_base + {{2{r_fs_q[13]}}, r_fs_q};
    assign w_slot   = w_slot16[TABLE_LOG-1:0];

    // Bits handed to the packer: low nb state bits, or the low table-log state bits on flush
    assign w_pk_nb   = (r_state == S_FLUSH) ? NB_W'(TABLE_LOG) : w_nb;
    assign w_mask    = (TLP1'(1) << w_pk_nb) - TLP1'(1);
    assign w_cs_ext  = 16'(r_cstate);
    assign w_pk_bits = w_cs_ext[TABLE_LOG-1:0] & w_mask[TABLE_LOG-1:0];

    assign w_base_cnt  = (r_phase != PH_LOADING) ? '0 : r_scount;
    assign w_ovf       = (w_base_cnt >= SC_W'(MAX_SYMBOLS));
    assign w_sym_waddr = w_base_cnt[SB_AW-1:0];
    assign w_sym_we    = w_accept && (w_op == OP_DATA) && !w_ovf;
    assign w_tab_we    = w_accept && (w_op == OP_SYM_WRITE);
    assign w_ns_we     = w_accept && (w_op == OP_NS_WRITE);
    assign w_ns_waddr  = TABLE_LOG'(32'(w_in.table_index));
    assign w_ns_re     = (r_state == S_ISLOT) || (r_state == S_CALC);
    assign w_ob_raddr  = OB_AW'(r_dptr - DP_W'(2));
    assign w_ob_we     = (r_state == S_EMIT) && (r_bcount < BC_W'(MAX_OUT_BYTES))
                         && (w_pk_stat.byte_ready || (r_final && w_pk_stat.has_tail));
    assign w_total     = 32'(r_bcount) + 32'd2;

    tte_bit_packer #(
        .TABLE_LOG (TABLE_LOG),
        .NB_W      (NB_W)
    ) u_packer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_pk_ctrl),
        .i_bits         (w_pk_bits),
        .i_nb           (w_pk_nb),
        .o_stat         (w_pk_stat),
        .o_byte         (w_pk_byte),
        .o_payload_bits (w_payload)
    );

    always_ff @(posedge i_clk) begin
        if (w_sym_we) begin
            sym_mem[w_sym_waddr] <= w_in.data_byte;
        end
        r_sym_q <= sym_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            nb_mem[w_in.table_index[7:0]] <= w_in.delta_nb_bits;
            fs_mem[w_in.table_index[7:0]] <= w_in.delta_find_state;
        end
        r_dnb_q <= nb_mem[r_sym_q];
        r_fs_q  <= fs_mem[r_sym_q];
    end

    always_ff @(posedge i_clk) begin
        if (w_ns_we) begin
            ns_mem[w_ns_waddr] <= w_in.next_state_entry;
        end
        if (w_ns_re) begin
            r_ns_q <= ns_mem[w_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ob_we) begin
            ob_mem[r_bcount[OB_AW-1:0]] <= w_pk_byte;
        end
        r_ob_q <= ob_mem[w_ob_raddr];
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_scount   = r_scount;
        n_idx      = r_idx;
        n_bcount   = r_bcount;
        n_dptr     = r_dptr;
        n_cstate   = r_cstate;
        n_t        = r_t;
        n_sh       = r_sh;
        n_final    = r_final;
        n_dsel     = r_dsel;
        n_dlast    = r_dlast;
        n_dtlen    = r_dtlen;
        n_m_valid  = r_m_valid;
        n_m_byte   = r_m_byte;
        n_m_tlen   = r_m_tlen;
        n_m_status = r_m_status;
        n_m_last   = r_m_last;
        w_out_load = 1'b0;
        w_pk_ctrl  = '0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_DATA: begin
                            n_phase  = PH_LOADING;
                            if (r_phase != PH_LOADING) begin
                                n_dptr = '0;
                            end
                            n_scount = w_ovf ? w_base_cnt : w_base_cnt + SC_W'(1);
                            if (w_ovf) begin
                                w_out_load = 1'b1;
                                n_m_byte   = '0;
                                n_m_tlen   = '0;
                                n_m_last   = 1'b0;
                                n_m_status = STAT_OVERFLOW;
                            end
                            if (s_axis_tlast) begin
                                n_idx         = SB_AW'(n_scount - SC_W'(1));
                                n_bcount      = '0;
                                n_final       = 1'b0;
                                w_pk_ctrl.clear = 1'b1;
                                n_state       = S_ISYM;
                            end
                        end
                        OP_DRAIN: begin
                            if (r_phase != PH_DRAINING) begin
                                w_out_load = 1'b1;
                                n_m_byte   = '0;
                                n_m_tlen   = '0;
                                n_m_last   = 1'b0;
                                n_m_status = STAT_EMPTY;
                            end else begin
                                if (r_dptr == DP_W'(0)) begin
                                    n_dsel = DS_LO;
                                end else if (r_dptr == DP_W'(1)) begin
                                    n_dsel = DS_HI;
                                end else if ((32'(r_dptr) - 32'd2) < 32'(r_bcount)) begin
                                    n_dsel = DS_MEM;
                                end else begin
                                    n_dsel = DS_ZERO;
                                end
                                n_dtlen = w_total[TLEN_W-1:0];
                                n_dlast = (32'(r_dptr) + 32'd1) >= w_total;
                                if (n_dlast) begin
                                    n_phase = PH_LOADING;
                                    n_dptr  = '0;
                                end else begin
                                    n_dptr = r_dptr + DP_W'(1);
                                end
                                n_state = S_DRAIN;
                            end
                        end
                        default: begin
                            // table writes are handled at the memories
                        end
                    endcase
                end
            end
            S_ISYM:  n_state = S_ITAB;
            S_ITAB:  n_state = S_INB;
            S_INB: begin
                n_t     = w_t;
                n_sh    = (w_nb0 > 16'd31) ? 5'd31 : w_nb0[4:0];
                n_state = S_ISLOT;
            end
            S_ISLOT: n_state = S_EMIT;
            S_LOOP: begin
                if (r_idx == '0) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx   = r_idx - SB_AW'(1);
                    n_state = S_SYM;
                end
            end
            S_SYM:   n_state = S_TAB;
            S_TAB:   n_state = S_CALC;
            S_CALC: begin
                w_pk_ctrl.push = 1'b1;
                n_state        = S_EMIT;
            end
            S_FLUSH: begin
                w_pk_ctrl.push = 1'b1;
                n_final        = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (w_pk_stat.byte_ready) begin
                    // drain whole bytes one per cycle
                    w_pk_ctrl.pop = 1'b1;
                    if (w_ob_we) begin
                        n_bcount = r_bcount + BC_W'(1);
                    end
                end else if (r_final) begin
                    if (w_ob_we) begin
                        n_bcount = r_bcount + BC_W'(1);
                    end
                    n_phase  = PH_DRAINING;
                    n_scount = '0;
                    n_dptr   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_cstate = r_ns_q;
                    n_state  = S_LOOP;
                end
            end
            S_DRAIN: begin
                w_out_load = 1'b1;
                case (r_dsel)
                    DS_LO:   n_m_byte = w_payload[7:0];
                    DS_HI:   n_m_byte = w_payload[15:8];
                    DS_MEM:  n_m_byte = r_ob_q;
                    default: n_m_byte = '0;
                endcase
                n_m_tlen   = r_dtlen;
                n_m_last   = r_dlast;
                n_m_status = STAT_OK;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (w_out_load) begin
            n_m_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_LOADING;
            r_scount   <= '0;
            r_idx      <= '0;
            r_bcount   <= '0;
            r_dptr     <= '0;
            r_cstate   <= '0;
            r_final    <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_scount   <= n_scount;
            r_idx      <= n_idx;
            r_bcount   <= n_bcount;
            r_dptr     <= n_dptr;
            r_cstate   <= n_cstate;
            r_final    <= n_final;
            r_m_valid  <= n_m_valid;
        end
        r_t        <= n_t;
        r_sh       <= n_sh;
        r_dsel     <= n_dsel;
        r_dlast    <= n_dlast;
        r_dtlen    <= n_dtlen;
        r_m_byte   <= n_m_byte;
        r_m_tlen   <= n_m_tlen;
        r_m_status <= n_m_status;
        r_m_last   <= n_m_last;
    end

`ifndef ASSERT_OFF
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_m_valid || m_axis_tready))
        else $error("result loaded over one not yet taken");
    a_scount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scount <= SC_W'(MAX_SYMBOLS))
        else $error("symbol count beyond buffer depth");
    a_bcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcount <= BC_W'(MAX_OUT_BYTES))
        else $error("output byte count beyond buffer depth");
    a_drain_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> $past(r_phase == PH_DRAINING))
        else $error("drain result started outside the draining phase");
`endif

endmodule

`default_nettype wire

// ===== hdl/tte_bit_packer.sv =====
// MSB-first bit packer: shared shift unit that appends state bits and peels off bytes.
`default_nettype none

module tte_bit_packer
    import tte_pkg::*;
#(
    parameter int unsigned TABLE_LOG = 12,
    parameter int unsigned NB_W      = $clog2(TABLE_LOG + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_pack_ctrl           i_ctrl,
    input  wire logic [TABLE_LOG-1:0] i_bits,
    input  wire logic [NB_W-1:0]      i_nb,
    output t_pack_stat                o_stat,
    output logic [7:0]                o_byte,
    output logic [15:0]               o_payload_bits
);

    localparam int unsigned ACC_W = TABLE_LOG + 7;
    localparam int unsigned PD_W  = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [PD_W-1:0]  r_pend, n_pend;
    logic [15:0]      r_payload, n_payload;
    logic [ACC_W-1:0] w_hi;
    logic [ACC_W-1:0] w_lo;

    // Byte at the top of the pending bits, and the zero-padded tail
    assign w_hi = r_acc >> (r_pend - PD_W'(8));
    assign w_lo = r_acc << (PD_W'(8) - r_pend);

    assign o_stat.byte_ready = (r_pend >= PD_W'(8));
    assign o_stat.has_tail   = (r_pend != '0);
    assign o_byte            = o_stat.byte_ready ? w_hi[7:0] : w_lo[7:0];
    assign o_payload_bits    = r_payload;

    always_comb begin
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_payload = r_payload;
        if (i_ctrl.clear) begin
            n_acc     = '0;
            n_pend    = '0;
            n_payload = '0;
        end else if (i_ctrl.push) begin
            n_acc     = (r_acc << i_nb) | ACC_W'(i_bits);
            n_pend    = r_pend + PD_W'(i_nb);
            n_payload = r_payload + 16'(i_nb);
        end else if (i_ctrl.pop) begin
            n_pend = r_pend - PD_W'(8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_pend    <= '0;
            r_payload <= '0;
        end else begin
            r_acc     <= n_acc;
            r_pend    <= n_pend;
            r_payload <= n_payload;
        end
    end

`ifndef ASSERT_OFF
    a_push_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |-> (r_pend < PD_W'(8)))
        else $error("bits pushed while a whole byte is still pending");
    a_pop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |-> (r_pend >= PD_W'(8)))
        else $error("byte popped with fewer than eight bits pending");
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PD_W'(ACC_W))
        else $error("pending bit count exceeds accumulator width");
`endif

endmodule

`default_nettype wire

// ===== sim/tans_table_encoder_tb.sv =====
// Self-checking testbench for the table-driven ANS encoder: random table loads, messages and drains.
`default_nettype none

module tans_table_encoder_tb;
    import tte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_SYMBOLS   = 4096;
    localparam int unsigned MAX_OUT_BYTES = 8192;
    localparam int unsigned TABLE_LOG     = 12;
    localparam bit [31:0]   TABLE_SIZE    = 32'd1 << TABLE_LOG;
    localparam int unsigned RANDOM_ITEMS  = 950;

    typedef enum bit {
        PH_LOADING  = 1'b0,
        PH_DRAINING = 1'b1
    } t_phase;

    typedef struct {
        bit [7:0]        out_byte;
        bit              is_last;
        bit [TLEN_W-1:0] total_length;
        t_status         status;
    } t_reply;

    // Mirror of the encoder: tables, buffers and packer, advanced once per accepted request
    class encoder_mirror;
        bit [7:0]    sym_buf [MAX_SYMBOLS];
        bit [7:0]    out_buf [MAX_OUT_BYTES];
        bit [31:0]   nb_delta [256];
        bit [13:0]   find_off [256];
        bit [12:0]   next_state [TABLE_SIZE];
        bit [31:0]   coder_state;
        bit [31:0]   acc;
        bit [31:0]   pending;
        bit [31:0]   sym_count;
        bit [31:0]   byte_count;
        bit [31:0]   payload_bits;
        bit [31:0]   drain_ptr;
        t_phase      phase = PH_LOADING;
        t_reply      expected_replies [$];
        int unsigned faults;

        function bit [31:0] slot_for(bit [31:0] base, bit [7:0] sym);
            bit [31:0] off;
            off = {{18{find_off[sym][13]}}, find_off[sym]};
            return (base + off) & (TABLE_SIZE - 1);
        endfunction

        function void store_byte(bit [31:0] b);
            if (byte_count < MAX_OUT_BYTES) begin
                out_buf[byte_count] = b[7:0];
                byte_count++;
            end
        endfunction

        // append nb bits and flush up to two whole bytes, MSB first
        function void emit_bits(bit [31:0] bits, bit [31:0] nb);
            acc = (acc << nb) | bits;
            pending += nb;
            payload_bits = (payload_bits + nb) & 32'hffff;
            repeat (2) begin
                if (pending >= 8) begin
                    store_byte(acc >> (pending - 8));
                    pending -= 8;
                end
            end
            acc &= (32'd1 << pending) - 1;
        endfunction

        function void encode_message();
            bit [31:0] n, s0, dnb, nb0, t, sh, nb;
            bit [7:0]  s;
            n = sym_count;
            byte_count   = 0;
            acc          = 0;
            pending      = 0;
            payload_bits = 0;
            if (n == 0 || n > MAX_SYMBOLS) return;
            // seed the state from the last symbol
            s0  = sym_buf[n - 1];
            dnb = nb_delta[s0];
            nb0 = (dnb + ROUND_HALF) >> 16;
            t   = (nb0 << 16) - dnb;
            sh  = (nb0 > 31) ? 32'd31 : nb0;
            coder_state = next_state[slot_for(t >> sh, s0)];
            // walk the rest backwards
            for (bit [31:0] i = n - 1; i > 0; i--) begin
                s  = sym_buf[i - 1];
                nb = (coder_state + nb_delta[s]) >> 16;
                if (nb > TABLE_LOG) nb = TABLE_LOG;
                emit_bits(coder_state & ((32'd1 << nb) - 1), nb);
                coder_state = next_state[slot_for(coder_state >> nb, s)];
            end
            emit_bits(coder_state & (TABLE_SIZE - 1), TABLE_LOG);
            if (pending > 0) store_byte(acc << (8 - pending));
            acc       = 0;
            pending   = 0;
            sym_count = 0;
            drain_ptr = 0;
            phase     = PH_DRAINING;
        endfunction

        function void take_request(t_opcode op, t_in_data d, bit last);
            t_reply    r;
            bit        full;
            bit [31:0] total, p;
            r = '{out_byte: 8'd0, is_last: 1'b0, total_length: '0, status: STAT_OK};
            case (op)
                OP_SYM_WRITE: begin
                    nb_delta[d.table_index[7:0]] = d.delta_nb_bits;
                    find_off[d.table_index[7:0]] = d.delta_find_state;
                end
                OP_NS_WRITE: begin
                    next_state[d.table_index & (TABLE_SIZE - 1)] = d.next_state_entry;
                end
                OP_DATA: begin
                    // a symbol while draining drops the pending output
                    if (phase != PH_LOADING) begin
                        phase     = PH_LOADING;
                        sym_count = 0;
                        drain_ptr = 0;
                    end
                    full = sym_count >= MAX_SYMBOLS;
                    if (!full) begin
                        sym_buf[sym_count] = d.data_byte;
                        sym_count++;
                    end
                    if (last) encode_message();
                    if (full) begin
                        r.status = STAT_OVERFLOW;
                        expected_replies.push_back(r);
                    end
                end
                default: begin
                    if (phase != PH_DRAINING) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        total = byte_count + 2;
                        p     = drain_ptr;
                        if (p == 0)                  r.out_byte = payload_bits[7:0];
                        else if (p == 1)             r.out_byte = payload_bits[15:8];
                        else if (p - 2 < byte_count) r.out_byte = out_buf[p - 2];
                        r.total_length = total[TLEN_W-1:0];
                        if (p + 1 >= total) begin
                            r.is_last = 1'b1;
                            phase     = PH_LOADING;
                            drain_ptr = 0;
                        end else begin
                            drain_ptr = p + 1;
                        end
                    end
                    expected_replies.push_back(r);
                end
            endcase
        endfunction

        function int unsigned bytes_left();
            return (phase == PH_DRAINING) ? byte_count + 2 - drain_ptr : 0;
        endfunction

        function void check_reply(t_out_data got, logic [1:0] status, logic last);
            t_reply want;
            if (expected_replies.size() == 0) begin
                if (faults < 100) $error("reply with nothing outstanding: tdata %h", got);
                faults++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.out_byte !== want.out_byte) begin
                if (faults < 100)
                    $error("out_byte: expected %0d, actual %0d", want.out_byte, got.out_byte);
                faults++;
            end
            if (last !== want.is_last) begin
                if (faults < 100) $error("is_last: expected %0d, actual %0d", want.is_last, last);
                faults++;
            end
            if (got.total_length !== want.total_length) begin
                if (faults < 100)
                    $error("total_length: expected %0d, actual %0d",
                           want.total_length, got.total_length);
                faults++;
            end
            if (status !== want.status) begin
                if (faults < 100) $error("status: expected %0d, actual %0d", want.status, status);
                faults++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    encoder_mirror mirror = new();
    int unsigned   sent;
    bit            calm;

    tans_table_encoder #(
        .MAX_SYMBOLS   (MAX_SYMBOLS),
        .MAX_OUT_BYTES (MAX_OUT_BYTES),
        .TABLE_LOG     (TABLE_LOG)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tans_table_encoder_tb: errors");
        $finish;
    end

    // stall the result side about a third of the time, except in the calm stretch
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 32);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            mirror.check_reply(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    function automatic t_in_data random_fields();
        t_in_data d;
        d.pad              = 1'b0;
        d.data_byte        = $urandom_range(255);
        d.next_state_entry = $urandom_range(8191);
        d.delta_find_state = $urandom_range(16383);
        d.delta_nb_bits    = $urandom;
        d.table_index      = $urandom_range(4095);
        return d;
    endfunction

    // mostly small bit counts so that nb varies, now and then anything
    function automatic bit [31:0] pick_nb_delta();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'd0;
            2:       return 32'hffff_ffff;
            default: return ($urandom_range(13) << 16) | $urandom_range(65535);
        endcase
    endfunction

    task automatic send(input t_opcode op, input t_in_data d, input bit last);
        while (!calm && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= random_fields();
            s_axis_tuser  <= $urandom_range(3);
            s_axis_tlast  <= $urandom_range(1);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.take_request(op, d, last);
        sent++;
    endtask

    task automatic load_symbol(input bit [11:0] idx, input bit [31:0] dnb, input bit [13:0] dfs);
        t_in_data d;
        d                  = random_fields();
        d.table_index      = idx;
        d.delta_nb_bits    = dnb;
        d.delta_find_state = dfs;
        send(OP_SYM_WRITE, d, $urandom_range(1));
    endtask

    task automatic load_next(input bit [11:0] slot, input bit [12:0] value);
        t_in_data d;
        d                  = random_fields();
        d.table_index      = slot;
        d.next_state_entry = value;
        send(OP_NS_WRITE, d, $urandom_range(1));
    endtask

    task automatic feed_symbol(input bit [7:0] b, input bit last);
        t_in_data d;
        d           = random_fields();
        d.data_byte = b;
        send(OP_DATA, d, last);
    endtask

    task automatic pull_byte();
        send(OP_DRAIN, random_fields(), $urandom_range(1));
    endtask

    task automatic encode_run(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            feed_symbol($urandom_range(255), i == n - 1);
    endtask

    task automatic drain_out(input int unsigned most);
        int unsigned k;
        k = mirror.bytes_left();
        if (most < k) k = most;
        repeat (k) pull_byte();
    endtask

    task automatic scramble_table();
        if ($urandom_range(1))
            load_symbol($urandom_range(4095), pick_nb_delta(), $urandom_range(16383));
        else
            load_next($urandom_range(4095), $urandom_range(8191));
    endtask

    initial begin
        int unsigned mark, pick, n;
        t_in_data    d;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every table entry so that no encode reads an unwritten one
        for (int unsigned i = 0; i < 256; i++)
            load_symbol({4'($urandom_range(15)), 8'(i)}, pick_nb_delta(), $urandom_range(16383));
        for (int unsigned i = 0; i < TABLE_SIZE; i++)
            load_next(i, $urandom_range(8191));

        // directed: empty drain, table extremes, short messages, abandon mid-drain
        pull_byte();
        load_symbol(12'h000, 32'hffff_ffff, 14'h2000);
        load_symbol(12'hfff, 32'h0000_0000, 14'h1fff);
        load_symbol(12'h001, 32'h0040_0000, 14'h0000);
        load_next(12'h000, 13'h0000);
        load_next(12'hfff, 13'h1fff);
        feed_symbol(8'h00, 1'b0);
        feed_symbol(8'h01, 1'b0);
        feed_symbol(8'hff, 1'b1);
        drain_out(MAX_OUT_BYTES);
        feed_symbol(8'h01, 1'b1);
        drain_out(2);
        load_symbol(12'h0ff, 32'h000c_0000, 14'h3fff);
        feed_symbol(8'hff, 1'b1);
        drain_out(MAX_OUT_BYTES);
        pull_byte();

        // fill the symbol buffer to its depth and encode it, then drop that output with a short message
        encode_run(MAX_SYMBOLS);
        mirror.take_request(OP_DRAIN, random_fields(), 1'b0);
        void'(mirror.expected_replies.pop_back());
        drain_out(0);
        feed_symbol($urandom_range(255), 1'b0);
        feed_symbol($urandom_range(255), 1'b1);
        drain_out(MAX_OUT_BYTES);

        mark = sent;
        while (sent < mark + RANDOM_ITEMS) begin
            calm <= (sent - mark >= 350) && (sent - mark < 500);
            pick = $urandom_range(99);
            if (pick < 70) begin
                repeat ($urandom_range(2)) scramble_table();
                n = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
                encode_run(n);
                if ($urandom_range(6) == 0) begin
                    // leave the output half drained; the next symbol drops it
                    drain_out($urandom_range(4));
                    if ($urandom_range(1)) scramble_table();
                end else begin
                    drain_out(MAX_OUT_BYTES);
                    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) pull_byte();
                end
            end else begin
                d = random_fields();
                send(t_opcode'($urandom_range(3)), d, $urandom_range(3) == 0);
            end
        end
        calm <= 1'b0;
        s_axis_tvalid <= 1'b0;

        n = 0;
        while (mirror.expected_replies.size() != 0 && n < 200_000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (50) @(posedge i_clk);
        if (mirror.expected_replies.size() != 0) begin
            $error("%0d expected replies never arrived", mirror.expected_replies.size());
            mirror.faults++;
        end
        if (mirror.faults == 0) begin
            $display("tans_table_encoder_tb: clean");
        end else begin
            $display("tans_table_encoder_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== tans_table_encoder.f =====
hdl/tte_pkg.sv
hdl/tte_bit_packer.sv
hdl/tans_table_encoder.sv
sim/tans_table_encoder_tb.sv
